FILE: hw/rtl/sha256_stream_hasher_defines.svh
// assertion macros for the sha256 stream hasher
// used by the top level, no other dependencies
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/sha256_pkg.sv
// shared types, constants and functions of the sha256 stream hasher
// no dependencies
package sha256_pkg;
    localparam int BlockBytes = 64;
    localparam int BufAw = 6;
    localparam int WordW = 32;

    typedef enum logic [1:0] {
        FUNC_ABSORB   = 2'd0,
        FUNC_FINALIZE = 2'd1,
        FUNC_RESTART  = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef logic [WordW-1:0] word_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction
endpackage

FILE: hw/rtl/sha256_stream_hasher.sv
// Byte-stream SHA-256 hasher. Each request carries func (tuser) and a message byte
// (tdata). An absorb writes its byte into the 64-byte block ram; each filled block
// runs the compression engine: big-endian word loading from the ram, then 64 rounds,
// one per cycle, then the add step; no new byte is taken while a block compresses. A
// finalize writes the padding bytes one per cycle while no compression runs (up to
// 72, with up to two compressions), then sends the eight digest words H0..H7 on the
// m_ side, word 7 marked by tlast; a later finalize resends them. Absorbs after
// finalize are dropped; a restart reloads the initial hash values. The round rate is
// set by the single round datapath; the byte rate by the one write port of the block
// ram. s_tready is low while a block compresses or padding/words go.
// depends on sha256_pkg, sha256_ram, sha256_core and the defines header
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero pad
    output logic        m_tlast    // last_word
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // taking requests
        S_PAD  = 4'b0010,   // writing padding bytes
        S_WAIT = 4'b0100,   // compression running
        S_OUT  = 4'b1000    // sending digest words
    } state_t;

    state_t state_reg, state_next;
    logic [60:0] count_reg;
    logic        done_reg;
    logic        pad_reg;          // padding in progress
    logic [63:0] bits_reg;
    logic [3:0]  pad_phase_reg;    // 0: 0x80, 1: zeros, 2..9: length bytes
    logic [2:0]  widx_reg;
    logic        m_valid_reg;

    logic        s_fire, m_fire;
    logic        buf_we;
    logic [7:0]  buf_wdata;
    logic [BufAw-1:0] buf_raddr;
    logic [7:0]  buf_rdata;
    logic        core_start, core_busy, core_init;
    word_t       h_word;
    logic [60:0] count_inc;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE) && !core_busy;
    assign count_inc = count_reg + 61'd1;

    sha256_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
        .aclk(aclk), .we(buf_we), .waddr(count_reg[BufAw-1:0]), .wdata(buf_wdata),
        .raddr(buf_raddr), .rdata(buf_rdata));

    sha256_core u_core (
        .aclk(aclk), .aresetn(aresetn), .start(core_start), .init_h(core_init),
        .busy(core_busy), .buf_raddr(buf_raddr), .buf_rdata(buf_rdata),
        .h_sel(widx_reg), .h_word(h_word));

    // byte source for absorb or padding
    always_comb begin
        buf_we = 1'b0;
        buf_wdata = s_tdata;
        if (state_reg == S_IDLE && s_fire && func_t'(s_tuser) == FUNC_ABSORB && !done_reg)
            buf_we = 1'b1;
        if (state_reg == S_PAD) begin
            buf_we = 1'b1;
            priority if (pad_phase_reg == 4'd0) buf_wdata = 8'h80;
            else if (pad_phase_reg == 4'd1) buf_wdata = 8'h00;
            else buf_wdata = bits_reg[63 - 8*(pad_phase_reg - 4'd2) -: 8];
        end
    end

    assign core_start = buf_we && (count_inc[BufAw-1:0] == '0);
    assign core_init = s_fire && func_t'(s_tuser) == FUNC_RESTART;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_fire && func_t'(s_tuser) == FUNC_FINALIZE)
                state_next = done_reg ? S_OUT : S_PAD;
            S_PAD: begin
                if (pad_phase_reg == 4'd9) state_next = S_WAIT;
                else if (core_start) state_next = S_WAIT;
            end
            S_WAIT: if (!core_busy && !core_start) state_next = pad_reg ? S_PAD : S_OUT;
            S_OUT: if (m_fire && m_tlast) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg <= 1'b0;
            pad_reg <= 1'b0;
            widx_reg <= '0;
            m_valid_reg <= 1'b0;
            pad_phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (buf_we) count_reg <= count_inc;
            if (core_init) begin
                count_reg <= '0;
                done_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && state_next == S_PAD) begin
                bits_reg <= {count_reg, 3'b000};
                pad_reg <= 1'b1;
                pad_phase_reg <= 4'd0;
            end
            if (state_reg == S_PAD) begin
                priority if (pad_phase_reg == 4'd9) begin
                    pad_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else if (pad_phase_reg == 4'd0) begin
                    pad_phase_reg <= (count_inc[BufAw-1:0] == 6'd56) ? 4'd2 : 4'd1;
                end else if (pad_phase_reg == 4'd1) begin
                    if (count_inc[BufAw-1:0] == 6'd56) pad_phase_reg <= 4'd2;
                end else begin
                    pad_phase_reg <= pad_phase_reg + 4'd1;
                end
            end
            if (state_reg == S_OUT) begin
                // valid drops right after the last word goes
                m_valid_reg <= !(m_fire && m_tlast);
                if (m_fire) widx_reg <= widx_reg + 3'd1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {5'd0, widx_reg, h_word};
    assign m_tlast = (widx_reg == 3'd7);

    `SHA_ASSERT_IMPL(a_no_out_idle, aclk, aresetn, m_tvalid, state_reg == S_OUT,
        "digest word outside output phase")
    `SHA_ASSERT_IMPL(a_busy_stall, aclk, aresetn, core_busy, !s_tready,
        "request accepted during compression")
    `SHA_ASSERT_NEXT(a_last_wrap, aclk, aresetn, m_fire && m_tlast, widx_reg == 3'd0,
        "word index not rewound after last word")
endmodule

FILE: hw/rtl/sha256_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sha256_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/sha256_core.sv
// sha256 compression engine: 64 rounds, one per cycle, schedule in a 16-word shift window
// depends on sha256_pkg
module sha256_core
    import sha256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic       init_h,
    output logic       busy,
    output logic [BufAw-1:0] buf_raddr,
    input  logic [7:0] buf_rdata,
    input  logic [2:0] h_sel,
    output word_t      h_word
);
    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_LOAD = 4'b0010,
        C_RND  = 4'b0100,
        C_ADD  = 4'b1000
    } cstate_t;

    cstate_t state_reg, state_next;
    word_t h_reg [8];
    word_t v_reg [8];
    logic [BufAw:0] lcnt_reg;      // byte fetch counter, one extra for read latency
    logic [5:0] t_reg;
    word_t wbuf_reg;               // assembled big-endian word
    word_t w16_reg [16];
    // schedule window kept as shift line, each word read at a fixed tap

    assign busy = (state_reg != C_IDLE);
    assign buf_raddr = lcnt_reg[BufAw-1:0];
    assign h_word = h_reg[h_sel];

    word_t w_cur, s0, s1, t1, t2;
    always_comb begin
        s0 = rotr(w16_reg[1], 7) ^ rotr(w16_reg[1], 18) ^ (w16_reg[1] >> 3);
        s1 = rotr(w16_reg[14], 17) ^ rotr(w16_reg[14], 19) ^ (w16_reg[14] >> 10);
        w_cur = (t_reg < 6'd16) ? w16_reg[0] : (s1 + w16_reg[9] + s0 + w16_reg[0]);
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[t_reg] + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (start) state_next = C_LOAD;
            C_LOAD: if (lcnt_reg == 7'd64) state_next = C_RND;
            C_RND:  if (t_reg == 6'd63) state_next = C_ADD;
            C_ADD:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
        end else begin
            state_reg <= state_next;
            if (init_h) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
            end else if (state_reg == C_ADD) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            C_IDLE: begin
                lcnt_reg <= start ? 7'd1 : 7'd0;
                t_reg <= '0;
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            end
            C_LOAD: begin
                lcnt_reg <= lcnt_reg + 7'd1;
                wbuf_reg <= {wbuf_reg[23:0], buf_rdata};
                if (lcnt_reg[1:0] == 2'd0) begin
                    for (int i = 0; i < 15; i++) w16_reg[i] <= w16_reg[i+1];
                    w16_reg[15] <= {wbuf_reg[23:0], buf_rdata};
                end
            end
            C_RND: begin
                t_reg <= t_reg + 6'd1;
                for (int i = 0; i < 15; i++) w16_reg[i] <= w16_reg[i+1];
                w16_reg[15] <= w_cur;
                v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            C_ADD: ;
            default: ;
        endcase
    end
endmodule
